// File: hdl/sfc_pkg.sv
// ----------------------------------------------------------------------------
// sfc_pkg
// Shared types, codes and constants of the sprite frame compositor.
// ----------------------------------------------------------------------------
package sfc_pkg;

	// item kinds, carried on s_tuser
	localparam logic [1:0] ACT_BEGIN = 2'd0;
	localparam logic [1:0] ACT_PLACE = 2'd1;
	localparam logic [1:0] ACT_DRAW  = 2'd2;
	localparam logic [1:0] ACT_READ  = 2'd3;

	// register indexes
	localparam int CFG_IDX_W = 3;
	localparam int CFG_W     = 24;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BG     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FINDEX = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_FPS    = 3'd4;

	// register reset values
	localparam logic [8:0] WIDTH_RST  = 9'd256;
	localparam logic [8:0] HEIGHT_RST = 9'd256;
	localparam logic [7:0] FPS_RST    = 8'd30;

	// default geometry
	localparam int DEF_MAX_WIDTH       = 256;
	localparam int DEF_MAX_HEIGHT      = 256;
	localparam int DEF_MAX_SPRITE_SIDE = 1024;

	// stream word layout
	localparam int TDATA_W  = 152;
	localparam int TUSER_W  = 2;
	localparam int OUT_W    = 32;
	localparam int RGB_W    = 24;
	localparam logic [OUT_W-1:0] ALPHA_FF = 32'hFF00_0000;

	// frame dimensions up to 4096 need 13 bits
	localparam int DIM_W = 13;

	// placement arithmetic
	localparam int NUM_W     = 50;	// signed numerator
	localparam int MAG_W     = 49;	// numerator magnitude, quotient
	localparam int DEN_W     = 17;	// 2*r*r
	localparam int DIV_CNT_W = 6;

	typedef struct packed {
		logic accept;
		logic fill_step;
		logic prep;
		logic mul;
		logic sum;
		logic div_step;
		logic fin;
		logic axis_y;
	} sfc_cmd_t;

	typedef struct packed {
		logic rd_busy;
		logic fill_last;
		logic div_last;
	} sfc_sts_t;

endpackage

// File: hdl/sfc_ram.sv
// ----------------------------------------------------------------------------
// sfc_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module sfc_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 65536,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: hdl/sfc_datapath.sv
// ----------------------------------------------------------------------------
// sfc_datapath
// Config registers, placement multiply/divide unit, draw/read pipe,
// frame store and output buffer.
// ----------------------------------------------------------------------------
module sfc_datapath import sfc_pkg::*; #(
	parameter int MAX_WIDTH       = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT      = DEF_MAX_HEIGHT,
	parameter int MAX_SPRITE_SIDE = DEF_MAX_SPRITE_SIDE
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  sfc_cmd_t             cmd,
	output sfc_sts_t             sts,
	input  logic [TDATA_W-1:0]   s_tdata,
	input  logic [TUSER_W-1:0]   s_tuser,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [OUT_W-1:0]     m_tdata
);

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	// config registers
	logic [8:0]       width_q, height_q;
	logic [RGB_W-1:0] bg_q;
	logic [15:0]      findex_q;
	logic [7:0]       fps_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RST;
			height_q <= HEIGHT_RST;
			bg_q     <= '0;
			findex_q <= '0;
			fps_q    <= FPS_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_WIDTH:  width_q  <= cfg_data[8:0];
				REG_HEIGHT: height_q <= cfg_data[8:0];
				REG_BG:     bg_q     <= cfg_data[RGB_W-1:0];
				REG_FINDEX: findex_q <= cfg_data[15:0];
				REG_FPS:    fps_q    <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// active size, clamped to the store
	logic [DIM_W-1:0] w_eff, h_eff;
	assign w_eff = ({4'b0, width_q} > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH)
		: {4'b0, width_q};
	assign h_eff = ({4'b0, height_q} > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT)
		: {4'b0, height_q};

	// input word fields
	logic [15:0] in_pos_x, in_pos_y, in_vel_x, in_vel_y, in_acc_x, in_acc_y;
	assign in_pos_x = s_tdata[15:0];
	assign in_pos_y = s_tdata[31:16];
	assign in_vel_x = s_tdata[47:32];
	assign in_vel_y = s_tdata[63:48];
	assign in_acc_x = s_tdata[79:64];
	assign in_acc_y = s_tdata[95:80];

	// ---------------- placement unit ----------------
	logic [15:0] pos_x_q, pos_y_q, vel_x_q, vel_y_q, acc_x_q, acc_y_q;
	logic [23:0] fr_q;
	logic [31:0] ff_q;
	logic [DEN_W-1:0] den_q;
	logic signed [40:0] p1_q;
	logic signed [48:0] p2_q;
	logic             neg_q;
	logic [MAG_W-1:0] quo_q;
	logic [DEN_W-1:0] rem_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic signed [31:0] origin_x_q, origin_y_q;

	logic [7:0]  r_eff;
	logic signed [15:0] vel_sel, acc_sel, pos_sel;
	logic signed [NUM_W-1:0] num;
	logic [DEN_W:0] rem_sh;
	logic           qbit;
	logic [DEN_W:0] rem_sub;
	logic signed [NUM_W-1:0] q_signed;
	logic signed [NUM_W:0]   o_sum;
	logic signed [31:0]      o_sat;

	assign r_eff   = (fps_q == 8'd0) ? 8'd1 : fps_q;
	assign vel_sel = cmd.axis_y ? vel_y_q : vel_x_q;
	assign acc_sel = cmd.axis_y ? acc_y_q : acc_x_q;
	assign pos_sel = cmd.axis_y ? pos_y_q : pos_x_q;

	// numerator 2*v*f*r + a*f*f
	assign num = (NUM_W'(p1_q) <<< 1) + NUM_W'(p2_q);

	// one restoring division step
	assign rem_sh  = {rem_q, quo_q[MAG_W-1]};
	assign qbit    = rem_sh >= {1'b0, den_q};
	assign rem_sub = rem_sh - {1'b0, den_q};

	// sign back, add base position, saturate
	assign q_signed = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
	assign o_sum    = (NUM_W+1)'(pos_sel) + (NUM_W+1)'(q_signed);
	always_comb begin
		if (o_sum[NUM_W:31] == '0 || o_sum[NUM_W:31] == '1) begin
			o_sat = o_sum[31:0];
		end else if (o_sum[NUM_W]) begin
			o_sat = 32'sh8000_0000;
		end else begin
			o_sat = 32'sh7FFF_FFFF;
		end
	end

	// placement operand registers
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			pos_x_q <= in_pos_x;
			pos_y_q <= in_pos_y;
			vel_x_q <= in_vel_x;
			vel_y_q <= in_vel_y;
			acc_x_q <= in_acc_x;
			acc_y_q <= in_acc_y;
		end
		if (cmd.prep) begin
			fr_q  <= {8'b0, findex_q} * {16'b0, r_eff};
			ff_q  <= {16'b0, findex_q} * {16'b0, findex_q};
			den_q <= {({8'b0, r_eff} * {8'b0, r_eff}), 1'b0};
		end
		if (cmd.mul) begin
			p1_q <= vel_sel * $signed({1'b0, fr_q});
			p2_q <= acc_sel * $signed({1'b0, ff_q});
		end
		if (cmd.sum) begin
			neg_q <= num[NUM_W-1];
			quo_q <= num[NUM_W-1] ? MAG_W'(-num) : MAG_W'(num);
			rem_q <= '0;
		end else if (cmd.div_step) begin
			rem_q <= qbit ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
			quo_q <= {quo_q[MAG_W-2:0], qbit};
		end
	end

	// divide step counter and origin
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= '0;
			origin_x_q <= '0;
			origin_y_q <= '0;
		end else begin
			if (cmd.sum) begin
				cnt_q <= '0;
			end else if (cmd.div_step) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (cmd.fin && !cmd.axis_y) begin
				origin_x_q <= o_sat;
			end
			if (cmd.fin && cmd.axis_y) begin
				origin_y_q <= o_sat;
			end
		end
	end

	assign sts.div_last = cnt_q == DIV_CNT_W'(MAG_W - 1);

	// ---------------- draw / read pipe ----------------
	logic             v_s1, rd_s2, in_s2;
	logic [1:0]       act_s1;
	logic [9:0]       col_s1, row_s1;
	logic [31:0]      argb_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= cmd.accept && (s_tuser == ACT_DRAW || s_tuser == ACT_READ);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			act_s1  <= s_tuser;
			col_s1  <= s_tdata[105:96];
			row_s1  <= s_tdata[115:106];
			argb_s1 <= s_tdata[147:116];
		end
	end

	// draw target and clipping
	logic signed [32:0] fx, fy;
	logic draw_ok, draw_we, rd_s1, rd_in;
	logic [AW-1:0] draw_addr, rd_addr;

	assign fx = 33'(origin_x_q) + $signed({23'b0, col_s1});
	assign fy = 33'(origin_y_q) + $signed({23'b0, row_s1});
	assign draw_ok = (32'(col_s1) < 32'(MAX_SPRITE_SIDE))
		&& (32'(row_s1) < 32'(MAX_SPRITE_SIDE))
		&& !fx[32] && !fy[32]
		&& (fx < $signed({20'b0, w_eff})) && (fy < $signed({20'b0, h_eff}))
		&& (argb_s1[31:24] != 8'd0);
	assign draw_we   = v_s1 && act_s1 == ACT_DRAW && draw_ok;
	assign draw_addr = AW'(32'(fy[11:0]) * 32'(MAX_WIDTH) + 32'(fx[11:0]));

	assign rd_s1   = v_s1 && act_s1 == ACT_READ;
	assign rd_in   = ({3'b0, col_s1} < w_eff) && ({3'b0, row_s1} < h_eff);
	assign rd_addr = AW'(32'(row_s1) * 32'(MAX_WIDTH) + 32'(col_s1));

	// clear sweep address
	logic [AW-1:0] fill_addr_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_addr_q <= '0;
		end else if (cmd.fill_step) begin
			fill_addr_q <= sts.fill_last ? '0 : fill_addr_q + 1'b1;
		end
	end
	assign sts.fill_last = fill_addr_q == AW'(DEPTH - 1);

	// frame store: the sweep wins the write port, it overwrites any draw
	logic             ram_we;
	logic [AW-1:0]    ram_waddr;
	logic [RGB_W-1:0] ram_wdata, ram_rdata;

	assign ram_we    = cmd.fill_step || draw_we;
	assign ram_waddr = cmd.fill_step ? fill_addr_q : draw_addr;
	assign ram_wdata = cmd.fill_step ? bg_q : argb_s1[RGB_W-1:0];

	sfc_ram #(
		.WIDTH(RGB_W),
		.DEPTH(DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(rd_addr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_s2 <= 1'b0;
		end else begin
			rd_s2 <= rd_s1;
		end
	end
	always_ff @(posedge clk) begin
		in_s2 <= rd_in;
	end

	// ---------------- output register plus skid ----------------
	logic [OUT_W-1:0] res, out_q, skid_q, out_d, skid_d;
	logic             out_v_q, skid_v_q, out_v_d, skid_v_d, take;

	assign res  = in_s2 ? (ALPHA_FF | {8'b0, ram_rdata}) : '0;
	assign take = out_v_q && m_tready;

	always_comb begin
		out_d    = out_q;
		out_v_d  = out_v_q;
		skid_d   = skid_q;
		skid_v_d = skid_v_q;
		if (take) begin
			if (skid_v_q) begin
				out_d    = skid_q;
				skid_v_d = 1'b0;
			end else begin
				out_v_d = 1'b0;
			end
		end
		if (rd_s2) begin
			if (!out_v_d) begin
				out_d   = res;
				out_v_d = 1'b1;
			end else begin
				skid_d   = res;
				skid_v_d = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			out_v_q  <= out_v_d;
			skid_v_q <= skid_v_d;
		end
	end
	always_ff @(posedge clk) begin
		out_q  <= out_d;
		skid_q <= skid_d;
	end

	assign m_tvalid    = out_v_q;
	assign m_tdata     = out_q;
	assign sts.rd_busy = rd_s1 || rd_s2 || skid_v_q;

endmodule

// File: hdl/sfc_ctrl.sv
// ----------------------------------------------------------------------------
// sfc_ctrl
// Controller: takes items, runs the clear sweep and the placement sequence.
// ----------------------------------------------------------------------------
module sfc_ctrl import sfc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [TUSER_W-1:0] s_tuser,
	input  sfc_sts_t           sts,
	output sfc_cmd_t           cmd
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_FILL = 3'd1;
	localparam logic [2:0] S_PREP = 3'd2;
	localparam logic [2:0] S_MUL  = 3'd3;
	localparam logic [2:0] S_SUM  = 3'd4;
	localparam logic [2:0] S_DIV  = 3'd5;
	localparam logic [2:0] S_FIN  = 3'd6;

	logic [2:0] state_q, state_d;
	logic       axis_q;
	logic       acc;

	assign s_tready = state_q == S_IDLE && !sts.rd_busy;
	assign acc      = s_tvalid && s_tready;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (acc && s_tuser == ACT_BEGIN) begin
					state_d = S_FILL;
				end else if (acc && s_tuser == ACT_PLACE) begin
					state_d = S_PREP;
				end
			end
			S_FILL: if (sts.fill_last) state_d = S_IDLE;
			S_PREP: state_d = S_MUL;
			S_MUL:  state_d = S_SUM;
			S_SUM:  state_d = S_DIV;
			S_DIV:  if (sts.div_last) state_d = S_FIN;
			S_FIN:  state_d = axis_q ? S_IDLE : S_MUL;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			axis_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_PREP) begin
				axis_q <= 1'b0;
			end else if (state_q == S_FIN) begin
				axis_q <= 1'b1;
			end
		end
	end

	// commands
	assign cmd.accept    = acc;
	assign cmd.fill_step = state_q == S_FILL;
	assign cmd.prep      = state_q == S_PREP;
	assign cmd.mul       = state_q == S_MUL;
	assign cmd.sum       = state_q == S_SUM;
	assign cmd.div_step  = state_q == S_DIV;
	assign cmd.fin       = state_q == S_FIN;
	assign cmd.axis_y    = axis_q;

endmodule

// File: hdl/sprite_frame_compositor.sv
// ----------------------------------------------------------------------------
// sprite_frame_compositor
// Sprite compositor into a frame store with clipping and alpha-zero skip.
// Draw items: one per cycle while idle with no read in flight, each written
//   in the cycle after acceptance. Read items: result on m_tdata via s1, the
//   store read and output registers; next item after pipe and skid drain.
// Begin frame: clear sweep of MAX_WIDTH*MAX_HEIGHT words (65536), one store
//   word a cycle. Placement: prep; per axis mul, sum, bit-serial divide.
// Reset: arst_n asynchronous; config, state, origin reset; store undefined.
// ----------------------------------------------------------------------------
module sprite_frame_compositor import sfc_pkg::*; #(
	parameter int MAX_WIDTH       = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT      = DEF_MAX_HEIGHT,
	parameter int MAX_SPRITE_SIDE = DEF_MAX_SPRITE_SIDE
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// pos_x, pos_y, vel_x, vel_y, acc_x, acc_y, col, row, pixel_argb, pad
	input  logic [TDATA_W-1:0]   s_tdata,
	// action
	input  logic [TUSER_W-1:0]   s_tuser,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// read_argb
	output logic [OUT_W-1:0]     m_tdata
);

	sfc_cmd_t cmd;
	sfc_sts_t sts;

	sfc_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tuser (s_tuser),
		.sts     (sts),
		.cmd     (cmd)
	);

	sfc_datapath #(
		.MAX_WIDTH      (MAX_WIDTH),
		.MAX_HEIGHT     (MAX_HEIGHT),
		.MAX_SPRITE_SIDE(MAX_SPRITE_SIDE)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.cmd      (cmd),
		.sts      (sts),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// no input taken during the clear sweep
	a_fill_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fill_step |-> !s_tready)
		else $error("item accepted during clear sweep");

	// at most one sequencer step at a time
	a_one_step: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.fill_step, cmd.prep, cmd.mul, cmd.sum, cmd.div_step, cmd.fin}))
		else $error("overlapping sequencer steps");

	// a read in flight holds off the next word
	a_read_gap: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser == ACT_READ |=> !s_tready)
		else $error("word accepted behind a read in flight");

	// a begin frame item leads straight into the sweep
	a_fill_start: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser == ACT_BEGIN |=> cmd.fill_step)
		else $error("clear sweep did not start");

endmodule
